[hw/rtl/pid_controller_timed_core_assert.svh]
// assertion macros for the timed pid controller core
// expects signals clk and rst_n in the scope that uses them
`ifndef PID_CONTROLLER_TIMED_CORE_ASSERT_SVH
`define PID_CONTROLLER_TIMED_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PIDT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PIDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pidt_pkg.sv]
// shared types, constants and microcode rom for the timed pid controller
// no dependencies
package pidt_pkg;

    localparam int PC_W        = 4;
    localparam int DIV_STEPS   = 32;
    localparam int CNT_W       = 6;
    localparam int CFG_INDEX_W = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT = 3'd3;

    // input op code for a start item
    localparam logic OP_START = 1'b0;

    // magnitude clamp of one gain term
    localparam logic [63:0] TERM_LIMIT = 64'h2000_0000_0000_0000;

    // microcode addresses used as jump targets
    localparam logic [PC_W-1:0] PC_DIV   = 4'd4;
    localparam logic [PC_W-1:0] PC_START = 4'd14;
    localparam logic [PC_W-1:0] PC_DONE  = 4'd15;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_ERR_DT,
        UOP_MUL_ERR_DT,
        UOP_INTEG,
        UOP_DIV_STEP,
        UOP_MUL_HI,
        UOP_MUL_LO,
        UOP_TERM,
        UOP_START,
        UOP_DONE
    } uop_t;

    typedef enum logic [1:0] {
        TERM_P,
        TERM_I,
        TERM_D
    } term_t;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_START,
        COND_LOOP
    } cond_t;

    typedef struct packed {
        uop_t            uop;
        term_t           term;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    // control word plus the strobe that carries it out this cycle
    typedef struct packed {
        logic  exec;
        ctrl_t word;
    } step_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic accept;
        logic is_start;
        logic out_hold;
    } seq_status_t;

    // microcode program
    function automatic ctrl_t micro_rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        case (pc)
            4'd0:    w = '{UOP_NOP,        TERM_P, COND_START,  PC_START};
            4'd1:    w = '{UOP_ERR_DT,     TERM_P, COND_NEXT,   PC_DONE};
            4'd2:    w = '{UOP_MUL_ERR_DT, TERM_P, COND_NEXT,   PC_DONE};
            4'd3:    w = '{UOP_INTEG,      TERM_P, COND_NEXT,   PC_DONE};
            4'd4:    w = '{UOP_DIV_STEP,   TERM_P, COND_LOOP,   PC_DIV};
            4'd5:    w = '{UOP_MUL_HI,     TERM_P, COND_NEXT,   PC_DONE};
            4'd6:    w = '{UOP_MUL_LO,     TERM_P, COND_NEXT,   PC_DONE};
            4'd7:    w = '{UOP_TERM,       TERM_P, COND_NEXT,   PC_DONE};
            4'd8:    w = '{UOP_MUL_HI,     TERM_I, COND_NEXT,   PC_DONE};
            4'd9:    w = '{UOP_MUL_LO,     TERM_I, COND_NEXT,   PC_DONE};
            4'd10:   w = '{UOP_TERM,       TERM_I, COND_NEXT,   PC_DONE};
            4'd11:   w = '{UOP_MUL_HI,     TERM_D, COND_NEXT,   PC_DONE};
            4'd12:   w = '{UOP_MUL_LO,     TERM_D, COND_NEXT,   PC_DONE};
            4'd13:   w = '{UOP_TERM,       TERM_D, COND_ALWAYS, PC_DONE};
            4'd14:   w = '{UOP_START,      TERM_P, COND_NEXT,   PC_DONE};
            4'd15:   w = '{UOP_DONE,       TERM_P, COND_NEXT,   PC_DONE};
            default: w = '{UOP_NOP,        TERM_P, COND_NEXT,   PC_DONE};
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/pidt_seq.sv]
// microcode sequencer: step counter, loop counter and jump logic
// depends on pidt_pkg for the rom, control word and status types
module pidt_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  pidt_pkg::seq_status_t status,
    output pidt_pkg::step_t     step,
    output logic                busy
);

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    seq_state_t                     state_reg, state_next;
    logic [pidt_pkg::PC_W-1:0]      pc_reg, pc_next;
    logic [pidt_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    pidt_pkg::ctrl_t                word;
    logic                           run;
    logic                           hold;
    logic                           exec;
    logic                           taken;

    // decode current step
    always_comb
    begin
        word = pidt_pkg::micro_rom(pc_reg);
        run  = (state_reg == SEQ_RUN);
        hold = (word.uop == pidt_pkg::UOP_DONE) && status.out_hold;
        exec = run && !hold;
        case (word.cond)
            pidt_pkg::COND_NEXT:   taken = 1'b0;
            pidt_pkg::COND_ALWAYS: taken = 1'b1;
            pidt_pkg::COND_START:  taken = status.is_start;
            pidt_pkg::COND_LOOP:   taken = (cnt_reg != pidt_pkg::CNT_W'(1));
            default:               taken = 1'b0;
        endcase
    end

    // next step and loop count
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        cnt_next   = cnt_reg;
        if (!run)
        begin
            if (status.accept)
            begin
                state_next = SEQ_RUN;
                pc_next    = '0;
            end
        end
        else if (exec)
        begin
            if (word.uop == pidt_pkg::UOP_DONE)
            begin
                state_next = SEQ_IDLE;
            end
            else
            begin
                pc_next = taken ? word.target : pc_reg + pidt_pkg::PC_W'(1);
            end
            // loop count reloads outside a loop, counts down inside it
            if (word.cond == pidt_pkg::COND_LOOP)
            begin
                cnt_next = cnt_reg - pidt_pkg::CNT_W'(1);
            end
            else
            begin
                cnt_next = pidt_pkg::CNT_W'(pidt_pkg::DIV_STEPS);
            end
        end
    end

    // state and registered control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            pc_reg    <= '0;
            cnt_reg   <= pidt_pkg::CNT_W'(pidt_pkg::DIV_STEPS);
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign step.exec = exec;
    assign step.word = word;
    assign busy      = run;

endmodule

[hw/rtl/pid_controller_timed_core.sv]
// timed pid controller core: configuration registers, datapath and output register
// depends on pidt_pkg, pidt_seq and pid_controller_timed_core_assert.svh
`include "pid_controller_timed_core_assert.svh"

// A sample item runs the error, integral, divide and gain term steps of the
// microcode from its input transfer until its result is in the output register,
// and a start item runs the start step; the next input transfer is taken in
// the cycle the result appears, so a new item waits until the last is done.
// The microcode holds a restoring divide for the derivative at one quotient bit
// per cycle and one shared 32x32 multiplier that forms the error times interval
// product and two partial products for each of the three gain terms. A finished
// result waits in the output register while the next item is already being
// worked on; the last step holds only if that register is still full and stalled.
// Configuration writes are always accepted and must be made while idle.
module pid_controller_timed_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pidt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               op,
    input  logic signed [31:0]                 measurement,
    input  logic [31:0]                        timestamp,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [31:0]                 drive,
    output logic                               not_started,
    output logic                               zero_interval,
    output logic                               saturated
);

    localparam logic [63:0] HI_LIMIT = 64'd1 << (29 + FRAC_BITS);
    localparam int          HI_SHIFT = 32 - FRAC_BITS;
    localparam int          LO_SHIFT = FRAC_BITS;

    localparam logic [31:0] MAX32 = 32'h7fff_ffff;
    localparam logic [31:0] MIN32 = 32'h8000_0000;
    localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

    // control state and registers with reset values
    logic [31:0] gain_p_reg, gain_p_next;
    logic [31:0] gain_i_reg, gain_i_next;
    logic [31:0] gain_d_reg, gain_d_next;
    logic [31:0] setpoint_reg, setpoint_next;
    logic [63:0] integral_reg, integral_next;
    logic [31:0] last_error_reg, last_error_next;
    logic [31:0] last_time_reg, last_time_next;
    logic        running_reg, running_next;
    logic        out_valid_reg, out_valid_next;

    // payload and working registers
    logic        op_reg, op_next;
    logic [31:0] meas_reg, meas_next;
    logic [31:0] ts_reg, ts_next;
    logic [31:0] err_reg, err_next;
    logic [31:0] dt_reg, dt_next;
    logic        ns_reg, ns_next;
    logic        zero_reg, zero_next;
    logic        sat_reg, sat_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] phi_reg, phi_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic        num_neg_reg, num_neg_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] drive_reg, drive_next;
    logic        ns_out_reg, ns_out_next;
    logic        zero_out_reg, zero_out_next;
    logic        sat_out_reg, sat_out_next;

    // datapath helpers
    logic                  in_accept;
    logic                  busy;
    pidt_pkg::step_t       step;
    pidt_pkg::seq_status_t status;
    logic [32:0]           err_diff;
    logic                  err_ovf;
    logic [31:0]           err_sat;
    logic [31:0]           dt_val;
    logic [31:0]           err_mag;
    logic [63:0]           prod_signed;
    logic [64:0]           integ_sum;
    logic                  integ_ovf;
    logic [63:0]           integ_new;
    logic [63:0]           integ_mag;
    logic [32:0]           num;
    logic [32:0]           num_mag;
    logic [32:0]           div_shift;
    logic [32:0]           div_diff;
    logic                  div_ge;
    logic [31:0]           gain_sel;
    logic [63:0]           ub_sel;
    logic                  b_neg;
    logic [31:0]           gain_mag;
    logic                  term_neg;
    logic [31:0]           mul_a;
    logic [31:0]           mul_b;
    logic [63:0]           mul_p;
    logic [63:0]           q_sum;
    logic [63:0]           q_mag;
    logic [63:0]           term_val;
    logic                  acc_ovf;
    logic [31:0]           drive_sat;
    logic                  done_exec;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = busy;
    assign cfg_ready = 1'b1;

    // sequencer
    assign status.accept   = in_accept;
    assign status.is_start = (op_reg == pidt_pkg::OP_START);
    assign status.out_hold = out_valid_reg && out_stall;

    pidt_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .step   (step),
        .busy   (busy)
    );

    // error with saturation and time interval
    always_comb
    begin
        err_diff = {setpoint_reg[31], setpoint_reg} - {meas_reg[31], meas_reg};
        err_ovf  = err_diff[32] ^ err_diff[31];
        err_sat  = err_ovf ? (err_diff[32] ? MIN32 : MAX32) : err_diff[31:0];
        dt_val   = ts_reg - last_time_reg;
        err_mag  = err_reg[31] ? 32'd0 - err_reg : err_reg;
    end

    // saturating integral update
    always_comb
    begin
        prod_signed = err_reg[31] ? 64'd0 - prod_reg : prod_reg;
        integ_sum   = {integral_reg[63], integral_reg} + {prod_signed[63], prod_signed};
        integ_ovf   = integ_sum[64] ^ integ_sum[63];
        integ_new   = integ_ovf ? (integ_sum[64] ? MIN64 : MAX64) : integ_sum[63:0];
        integ_mag   = integral_reg[63] ? 64'd0 - integral_reg : integral_reg;
    end

    // derivative numerator and one restoring divide step
    always_comb
    begin
        num       = {err_reg[31], err_reg} - {last_error_reg[31], last_error_reg};
        num_mag   = num[32] ? 33'd0 - num : num;
        div_shift = {rem_reg, quo_reg[31]};
        div_ge    = (div_shift >= {1'b0, dt_reg});
        div_diff  = div_shift - {1'b0, dt_reg};
    end

    // gain term operand select
    always_comb
    begin
        case (step.word.term)
            pidt_pkg::TERM_P:
            begin
                gain_sel = gain_p_reg;
                ub_sel   = {32'd0, err_mag};
                b_neg    = err_reg[31];
            end
            pidt_pkg::TERM_I:
            begin
                gain_sel = gain_i_reg;
                ub_sel   = integ_mag;
                b_neg    = integral_reg[63];
            end
            pidt_pkg::TERM_D:
            begin
                gain_sel = gain_d_reg;
                ub_sel   = {32'd0, zero_reg ? 32'd0 : quo_reg};
                b_neg    = num_neg_reg;
            end
            default:
            begin
                gain_sel = '0;
                ub_sel   = '0;
                b_neg    = 1'b0;
            end
        endcase
        gain_mag = gain_sel[31] ? 32'd0 - gain_sel : gain_sel;
        term_neg = gain_sel[31] ^ b_neg;
    end

    // shared unsigned multiplier
    always_comb
    begin
        case (step.word.uop)
            pidt_pkg::UOP_MUL_ERR_DT:
            begin
                mul_a = err_mag;
                mul_b = dt_reg;
            end
            pidt_pkg::UOP_MUL_HI:
            begin
                mul_a = gain_mag;
                mul_b = ub_sel[63:32];
            end
            default:
            begin
                mul_a = gain_mag;
                mul_b = ub_sel[31:0];
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // term from partial products, shift, clamp and sign
    always_comb
    begin
        q_sum    = (phi_reg << HI_SHIFT) + (prod_reg >> LO_SHIFT);
        q_mag    = ((phi_reg >= HI_LIMIT) || (q_sum > pidt_pkg::TERM_LIMIT))
                   ? pidt_pkg::TERM_LIMIT : q_sum;
        term_val = term_neg ? 64'd0 - q_mag : q_mag;
    end

    // drive saturation
    always_comb
    begin
        acc_ovf   = !((&acc_reg[63:31]) || (~|acc_reg[63:31]));
        drive_sat = acc_ovf ? (acc_reg[63] ? MIN32 : MAX32) : acc_reg[31:0];
    end

    // next values
    always_comb
    begin
        gain_p_next     = gain_p_reg;
        gain_i_next     = gain_i_reg;
        gain_d_next     = gain_d_reg;
        setpoint_next   = setpoint_reg;
        integral_next   = integral_reg;
        last_error_next = last_error_reg;
        last_time_next  = last_time_reg;
        running_next    = running_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        meas_next       = meas_reg;
        ts_next         = ts_reg;
        err_next        = err_reg;
        dt_next         = dt_reg;
        ns_next         = ns_reg;
        zero_next       = zero_reg;
        sat_next        = sat_reg;
        prod_next       = prod_reg;
        phi_next        = phi_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        num_neg_next    = num_neg_reg;
        acc_next        = acc_reg;
        drive_next      = drive_reg;
        ns_out_next     = ns_out_reg;
        zero_out_next   = zero_out_reg;
        sat_out_next    = sat_out_reg;

        // configuration write
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pidt_pkg::REG_GAIN_P:   gain_p_next   = cfg_data;
                pidt_pkg::REG_GAIN_I:   gain_i_next   = cfg_data;
                pidt_pkg::REG_GAIN_D:   gain_d_next   = cfg_data;
                pidt_pkg::REG_SETPOINT: setpoint_next = cfg_data;
                default:                ;
            endcase
        end

        // input transfer
        if (in_accept)
        begin
            op_next   = op;
            meas_next = measurement;
            ts_next   = timestamp;
        end

        // output transfer
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // microcode step
        if (step.exec)
        begin
            case (step.word.uop)
                pidt_pkg::UOP_ERR_DT:
                begin
                    err_next       = err_sat;
                    dt_next        = dt_val;
                    last_time_next = ts_reg;
                    ns_next        = !running_reg;
                    zero_next      = (dt_val == 32'd0);
                    sat_next       = err_ovf;
                end
                pidt_pkg::UOP_MUL_ERR_DT:
                begin
                    prod_next = mul_p;
                end
                pidt_pkg::UOP_INTEG:
                begin
                    integral_next   = integ_new;
                    sat_next        = sat_reg | integ_ovf;
                    quo_next        = num_mag[31:0];
                    rem_next        = '0;
                    num_neg_next    = num[32];
                    last_error_next = err_reg;
                    acc_next        = '0;
                end
                pidt_pkg::UOP_DIV_STEP:
                begin
                    rem_next = div_ge ? div_diff[31:0] : div_shift[31:0];
                    quo_next = {quo_reg[30:0], div_ge};
                end
                pidt_pkg::UOP_MUL_HI:
                begin
                    prod_next = mul_p;
                end
                pidt_pkg::UOP_MUL_LO:
                begin
                    phi_next  = prod_reg;
                    prod_next = mul_p;
                end
                pidt_pkg::UOP_TERM:
                begin
                    acc_next = acc_reg + term_val;
                end
                pidt_pkg::UOP_START:
                begin
                    integral_next   = '0;
                    last_error_next = setpoint_reg;
                    last_time_next  = ts_reg;
                    running_next    = 1'b1;
                    acc_next        = '0;
                    ns_next         = 1'b0;
                    zero_next       = 1'b0;
                    sat_next        = 1'b0;
                end
                pidt_pkg::UOP_DONE:
                begin
                    drive_next     = drive_sat;
                    ns_out_next    = ns_reg;
                    zero_out_next  = zero_reg;
                    sat_out_next   = sat_reg | acc_ovf;
                    out_valid_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // registers with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            setpoint_reg   <= '0;
            integral_reg   <= '0;
            last_error_reg <= '0;
            last_time_reg  <= '0;
            running_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            gain_p_reg     <= gain_p_next;
            gain_i_reg     <= gain_i_next;
            gain_d_reg     <= gain_d_next;
            setpoint_reg   <= setpoint_next;
            integral_reg   <= integral_next;
            last_error_reg <= last_error_next;
            last_time_reg  <= last_time_next;
            running_reg    <= running_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        meas_reg     <= meas_next;
        ts_reg       <= ts_next;
        err_reg      <= err_next;
        dt_reg       <= dt_next;
        ns_reg       <= ns_next;
        zero_reg     <= zero_next;
        sat_reg      <= sat_next;
        prod_reg     <= prod_next;
        phi_reg      <= phi_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        num_neg_reg  <= num_neg_next;
        acc_reg      <= acc_next;
        drive_reg    <= drive_next;
        ns_out_reg   <= ns_out_next;
        zero_out_reg <= zero_out_next;
        sat_out_reg  <= sat_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign drive         = drive_reg;
    assign not_started   = ns_out_reg;
    assign zero_interval = zero_out_reg;
    assign saturated     = sat_out_reg;

    // checks
    assign done_exec = step.exec && (step.word.uop == pidt_pkg::UOP_DONE);

    `PIDT_ASSERT_SAME(a_no_overwrite, done_exec, !status.out_hold, "stalled result overwritten")
    `PIDT_ASSERT_SAME(a_valid_from_done, $rose(out_valid_reg), $past(done_exec), "stray valid")
    `PIDT_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall, "no stall after transfer")

endmodule
